FILE: hw/rtl/autorange_volt_and_continuity_meter_core_assert.svh
// assertion macros shared by the meter checker
`ifndef AUTORANGE_VOLT_AND_CONTINUITY_METER_CORE_ASSERT_SVH
`define AUTORANGE_VOLT_AND_CONTINUITY_METER_CORE_ASSERT_SVH

// property checked while out of reset
`define AVCM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("avcm assertion failed");

// property checked at every edge, reset included
`define AVCM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("avcm assertion failed");

`endif

FILE: hw/rtl/avcm_pkg.sv
// shared types and constants of the volt and continuity meter
`timescale 1ns / 1ps
package avcm_pkg;

  localparam int unsigned KindW = 3;
  localparam int unsigned MvW   = 15;
  localparam int unsigned ResW  = 20;
  localparam int unsigned RefW  = 12;
  localparam int unsigned TolW  = 7;
  localparam int unsigned OhmW  = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [KindW-1:0] KIND_VOLT       = 3'd0;
  localparam logic [KindW-1:0] KIND_OHMS       = 3'd1;
  localparam logic [KindW-1:0] KIND_LIMIT_DOWN = 3'd2;
  localparam logic [KindW-1:0] KIND_LIMIT_UP   = 3'd3;
  localparam logic [KindW-1:0] KIND_MAX_RESET  = 3'd4;

  localparam logic [1:0] RANGE_NONE = 2'd0;
  localparam logic [1:0] RANGE_LOW  = 2'd1;
  localparam logic [1:0] RANGE_MID  = 2'd2;
  localparam logic [1:0] RANGE_TOP  = 2'd3;

  localparam logic [1:0] OHM_NONE   = 2'd0;
  localparam logic [1:0] OHM_OPEN   = 2'd1;
  localparam logic [1:0] OHM_SHORT  = 2'd2;
  localparam logic [1:0] OHM_CLOSED = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_LOW_THR  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HIGH_THR = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RES_A    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RES_C    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RES_D    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_REF_MV   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TOL_PCT  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_OPEN_THR = 3'd7;

  localparam logic [OhmW-1:0] OHM_SAT = 16'hFFFF;
  localparam logic [6:0]      PERCENT = 7'd100;
  localparam int unsigned     DivSteps = 16;

  typedef struct packed {
    logic load_item;
    logic mul1;
    logic mul2;
    logic check;
    logic div_step;
    logic grade;
    logic simple;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_ohms;
    logic special;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/avcm_ctrl.sv
// sequencer of the meter: issues datapath commands per item
`timescale 1ns / 1ps
module avcm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  avcm_pkg::sts_t  sts_i,
  output avcm_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_MUL2, ST_CHECK, ST_DIV, ST_GRADE, ST_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.is_ohms) begin
          cmd_o.mul1 = 1'b1;
          state_d = ST_MUL2;
        end else begin
          cmd_o.simple = 1'b1;
          state_d = ST_FINISH;
        end
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        cnt_d = '0;
        state_d = sts_i.special ? ST_GRADE : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(avcm_pkg::DivSteps - 1)) begin
          state_d = ST_GRADE;
        end
      end
      ST_GRADE: begin
        cmd_o.grade = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

FILE: hw/rtl/avcm_dp.sv
// meter datapath: registers, bridge arithmetic, divider and result register
`timescale 1ns / 1ps
module avcm_dp #(
  parameter int unsigned LIMIT_STEP = 25,
  parameter int unsigned LIMIT_MIN  = 25,
  parameter int unsigned LIMIT_MAX  = 500
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [19:0]           cfg_data_i,
  input  logic [2:0]            kind_i,
  input  logic [14:0]           sample_mv_i,
  input  avcm_pkg::cmd_t        cmd_i,
  output avcm_pkg::sts_t        sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            range_sel_o,
  output logic                  range_changed_o,
  output logic                  alert_on_o,
  output logic [14:0]           max_hold_mv_o,
  output logic [15:0]           resistance_ohms_o,
  output logic [1:0]            ohm_status_o,
  output logic                  tone_on_o,
  output logic [15:0]           limit_value_ohms_o
);

  // configuration
  logic [14:0] low_thr_q, high_thr_q;
  logic [19:0] ra_q, rc_q, rd_q;
  logic [11:0] ref_q;
  logic [6:0]  tol_q;
  logic [15:0] open_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= 15'd10000;
      high_thr_q <= 15'd20000;
      ra_q       <= 20'd1000;
      rc_q       <= 20'd1000;
      rd_q       <= 20'd1000;
      ref_q      <= 12'd3300;
      tol_q      <= 7'd1;
      open_thr_q <= 16'd1000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        avcm_pkg::REG_LOW_THR:  low_thr_q  <= cfg_data_i[14:0];
        avcm_pkg::REG_HIGH_THR: high_thr_q <= cfg_data_i[14:0];
        avcm_pkg::REG_RES_A:    ra_q       <= cfg_data_i;
        avcm_pkg::REG_RES_C:    rc_q       <= cfg_data_i;
        avcm_pkg::REG_RES_D:    rd_q       <= cfg_data_i;
        avcm_pkg::REG_REF_MV:   ref_q      <= cfg_data_i[11:0];
        avcm_pkg::REG_TOL_PCT:  tol_q      <= cfg_data_i[6:0];
        avcm_pkg::REG_OPEN_THR: open_thr_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // item and arithmetic registers
  logic [2:0]  kind_q;
  logic [14:0] v_q;
  logic [36:0] den_q;
  logic [31:0] a_q;
  logic [35:0] b_q;
  logic [51:0] p_q;
  logic        npos_q;
  logic [36:0] rem_q;
  logic [15:0] quo_q;
  logic        special_q;
  logic [15:0] res_q;
  logic [1:0]  status_q;
  logic        changed_q;

  // meter state
  logic [14:0] max_q;
  logic [1:0]  range_q;
  logic [15:0] last_q;
  logic [15:0] limit_q;
  logic        tone_q;

  logic [21:0] sum_all;
  logic [20:0] sum_cd;
  logic [35:0] a_ext, numd;
  logic        special_w;
  logic [15:0] special_res;
  logic [37:0] trial;
  logic [15:0] res_w, diff;
  logic [22:0] lhs, rhs;
  logic [1:0]  new_range;
  logic signed [17:0] dn;
  logic [16:0] up;

  assign sum_all = {2'b00, ra_q} + {2'b00, rc_q} + {2'b00, rd_q};
  assign sum_cd  = {1'b0, rc_q} + {1'b0, rd_q};
  assign a_ext   = {4'b0000, a_q};
  assign numd    = a_ext - b_q;

  // open probe, empty bridge, non-positive numerator or quotient overflow
  always_comb begin
    special_w   = 1'b1;
    special_res = avcm_pkg::OHM_SAT;
    if (v_q == '0 || den_q == '0) begin
      special_res = avcm_pkg::OHM_SAT;
    end else if (!npos_q) begin
      special_res = '0;
    end else if ({1'b0, p_q} >= {den_q, 16'h0000}) begin
      special_res = avcm_pkg::OHM_SAT;
    end else begin
      special_w = 1'b0;
    end
  end

  assign trial = {rem_q, quo_q[15]};
  assign res_w = special_q ? res_q : quo_q;
  assign diff  = (res_w > last_q) ? res_w - last_q : last_q - res_w;
  assign lhs   = 23'(avcm_pkg::PERCENT) * 23'(diff);
  assign rhs   = 23'(tol_q) * 23'(res_w);

  always_comb begin
    if (v_q >= high_thr_q) begin
      new_range = avcm_pkg::RANGE_TOP;
    end else if (v_q <= low_thr_q) begin
      new_range = avcm_pkg::RANGE_LOW;
    end else begin
      new_range = avcm_pkg::RANGE_MID;
    end
  end

  assign dn = $signed({2'b00, limit_q}) - $signed(18'(LIMIT_STEP));
  assign up = {1'b0, limit_q} + 17'(LIMIT_STEP);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q <= kind_i;
      v_q    <= sample_mv_i;
    end
    if (cmd_i.mul1) begin
      den_q <= 37'(v_q) * 37'(sum_all);
      a_q   <= 32'(ref_q) * 32'(rd_q);
      b_q   <= 36'(v_q) * 36'(sum_cd);
    end
    if (cmd_i.mul2) begin
      npos_q <= a_ext > b_q;
      p_q    <= 52'(numd[31:0]) * 52'(ra_q);
    end
    if (cmd_i.check) begin
      special_q <= special_w;
      rem_q     <= {1'b0, p_q[51:16]};
      quo_q     <= p_q[15:0];
    end
    if (cmd_i.div_step) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= 37'(trial - {1'b0, den_q});
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= trial[36:0];
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
  end

  // control-side and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= '0;
      range_q   <= avcm_pkg::RANGE_NONE;
      last_q    <= '0;
      limit_q   <= 16'(LIMIT_STEP);
      tone_q    <= 1'b0;
      res_q     <= '0;
      status_q  <= avcm_pkg::OHM_NONE;
      changed_q <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        res_q     <= '0;
        status_q  <= avcm_pkg::OHM_NONE;
        changed_q <= 1'b0;
      end
      if (cmd_i.check) begin
        res_q <= special_res;
      end
      if (cmd_i.grade) begin
        res_q <= res_w;
        if (lhs > rhs) begin
          last_q   <= res_w;
          status_q <= avcm_pkg::OHM_NONE;
        end else if (res_w > open_thr_q) begin
          status_q <= avcm_pkg::OHM_OPEN;
        end else if (res_w < limit_q) begin
          status_q <= avcm_pkg::OHM_SHORT;
          tone_q   <= 1'b1;
        end else begin
          status_q <= avcm_pkg::OHM_CLOSED;
          tone_q   <= 1'b0;
        end
      end
      if (cmd_i.simple) begin
        case (kind_q)
          avcm_pkg::KIND_VOLT: begin
            if (v_q > max_q) max_q <= v_q;
            changed_q <= (new_range != range_q);
            range_q   <= new_range;
          end
          avcm_pkg::KIND_LIMIT_DOWN: begin
            if (dn <= $signed(18'(LIMIT_MIN))) limit_q <= 16'(LIMIT_MIN);
            else limit_q <= dn[15:0];
          end
          avcm_pkg::KIND_LIMIT_UP: begin
            if (up > 17'(LIMIT_MAX)) limit_q <= 16'(LIMIT_MAX);
            else limit_q <= up[15:0];
          end
          avcm_pkg::KIND_MAX_RESET: max_q <= '0;
          default: ;
        endcase
      end
    end
  end

  // result register
  logic out_valid_q;
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      range_sel_o        <= range_q;
      range_changed_o    <= changed_q;
      alert_on_o         <= (range_q == avcm_pkg::RANGE_TOP);
      max_hold_mv_o      <= max_q;
      resistance_ohms_o  <= res_q;
      ohm_status_o       <= status_q;
      tone_on_o          <= tone_q;
      limit_value_ohms_o <= limit_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.is_ohms   = (kind_q == avcm_pkg::KIND_OHMS);
  assign sts_o.special   = special_w;
  assign sts_o.out_free  = out_free;

endmodule

FILE: hw/rtl/autorange_volt_and_continuity_meter_core.sv
// top level of the autorange volt and continuity meter core
// volt, limit and max-reset beats pass through the execute state and then wait in finish
// until the output is free; ohms beats take two multiply stages, a check, a 16-step
//   restoring divide and a grade, the divide skipped when open, shorted or saturated
// throughput: one beat in flight, next beat taken the cycle after its result is registered
// reset: asynchronous active low; control, config and meter state return to their defaults
`timescale 1ns / 1ps
module autorange_volt_and_continuity_meter_core #(
  parameter int unsigned LIMIT_STEP = 25,
  parameter int unsigned LIMIT_MIN  = 25,
  parameter int unsigned LIMIT_MAX  = 500
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel, always ready
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [14:0] sample_mv_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  range_sel_o,
  output logic        range_changed_o,
  output logic        alert_on_o,
  output logic [14:0] max_hold_mv_o,
  output logic [15:0] resistance_ohms_o,
  output logic [1:0]  ohm_status_o,
  output logic        tone_on_o,
  output logic [15:0] limit_value_ohms_o
);

  avcm_pkg::cmd_t cmd;
  avcm_pkg::sts_t sts;

  // register writes land the same cycle, so the port never pushes back
  assign cfg_ready_o = 1'b1;

  // sequencer: one beat in flight, result register parts the output side
  avcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath holds configuration, meter state, bridge maths and result register
  avcm_dp #(
    .LIMIT_STEP (LIMIT_STEP),
    .LIMIT_MIN  (LIMIT_MIN),
    .LIMIT_MAX  (LIMIT_MAX)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .kind_i             (kind_i),
    .sample_mv_i        (sample_mv_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .range_sel_o        (range_sel_o),
    .range_changed_o    (range_changed_o),
    .alert_on_o         (alert_on_o),
    .max_hold_mv_o      (max_hold_mv_o),
    .resistance_ohms_o  (resistance_ohms_o),
    .ohm_status_o       (ohm_status_o),
    .tone_on_o          (tone_on_o),
    .limit_value_ohms_o (limit_value_ohms_o)
  );

endmodule

FILE: hw/rtl/avcm_checker.sv
// port-level checker of the meter core and its bind
`timescale 1ns / 1ps
`include "autorange_volt_and_continuity_meter_core_assert.svh"
module avcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  range_sel_o,
  input logic        range_changed_o,
  input logic        alert_on_o,
  input logic [1:0]  ohm_status_o,
  input logic        tone_on_o,
  input logic [15:0] resistance_ohms_o
);

  `AVCM_ASSERT(a_stall_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(resistance_ohms_o))
  `AVCM_ASSERT(a_alert_top, clk_i, rst_ni, out_valid_o |-> alert_on_o == (range_sel_o == avcm_pkg::RANGE_TOP))
  `AVCM_ASSERT(a_short_tone, clk_i, rst_ni, out_valid_o && ohm_status_o == avcm_pkg::OHM_SHORT |-> tone_on_o)
  `AVCM_ASSERT(a_closed_quiet, clk_i, rst_ni, out_valid_o && ohm_status_o == avcm_pkg::OHM_CLOSED |-> !tone_on_o)
  `AVCM_ASSERT_ALWAYS(a_change_range, clk_i, out_valid_o && range_changed_o |-> range_sel_o != avcm_pkg::RANGE_NONE)

endmodule

bind autorange_volt_and_continuity_meter_core avcm_checker u_avcm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .range_sel_o       (range_sel_o),
  .range_changed_o   (range_changed_o),
  .alert_on_o        (alert_on_o),
  .ohm_status_o      (ohm_status_o),
  .tone_on_o         (tone_on_o),
  .resistance_ohms_o (resistance_ohms_o)
);

FILE: tb/tb_autorange_volt_and_continuity_meter_core.sv
// testbench for the autorange volt and continuity meter core
`timescale 1ns / 1ps
module tb_autorange_volt_and_continuity_meter_core;

  // one result beat of the meter
  typedef struct packed {
    logic [1:0]  range_sel;
    logic        range_changed;
    logic        alert_on;
    logic [14:0] max_hold_mv;
    logic [15:0] resistance_ohms;
    logic [1:0]  ohm_status;
    logic        tone_on;
    logic [15:0] limit_value_ohms;
  } meter_reading_t;

  localparam int StepOhms = 25;
  localparam int FloorOhms = 25;
  localparam int CeilOhms = 500;
  localparam int unsigned IdleLimit = 20000;

  // predictor of the meter plus the queue of readings still owed by the block
  class meter_scoreboard;
    logic [14:0] low_thr, high_thr;
    logic [19:0] res_a, res_c, res_d;
    logic [11:0] ref_mv;
    logic [6:0]  tol_pct;
    logic [15:0] open_thr;
    logic [14:0] max_mv;
    logic [1:0]  range;
    logic [15:0] last_ohms;
    logic [15:0] limit_ohms;
    logic        tone;
    meter_reading_t owed[$];
    int errors;

    function void reset_state();
      low_thr = 15'd10000; high_thr = 15'd20000;
      res_a = 20'd1000; res_c = 20'd1000; res_d = 20'd1000;
      ref_mv = 12'd3300; tol_pct = 7'd1; open_thr = 16'd1000;
      max_mv = '0; range = avcm_pkg::RANGE_NONE; last_ohms = '0;
      limit_ohms = 16'(StepOhms); tone = 1'b0;
      owed.delete(); errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [19:0] val);
      case (idx)
        avcm_pkg::REG_LOW_THR:  low_thr = val[14:0];
        avcm_pkg::REG_HIGH_THR: high_thr = val[14:0];
        avcm_pkg::REG_RES_A:    res_a = val;
        avcm_pkg::REG_RES_C:    res_c = val;
        avcm_pkg::REG_RES_D:    res_d = val;
        avcm_pkg::REG_REF_MV:   ref_mv = val[11:0];
        avcm_pkg::REG_TOL_PCT:  tol_pct = val[6:0];
        default:                open_thr = val[15:0];
      endcase
    endfunction

    // bridge formula, exact integer maths, clamped to 16 bits
    function logic [15:0] bridge_ohms(logic [14:0] v);
      logic [63:0] den, pos, neg, q;
      if (v == 0) return avcm_pkg::OHM_SAT;
      den = 64'(v) * (64'(res_a) + 64'(res_c) + 64'(res_d));
      if (den == 0) return avcm_pkg::OHM_SAT;
      pos = 64'(ref_mv) * 64'(res_d);
      neg = 64'(v) * (64'(res_c) + 64'(res_d));
      if (pos <= neg) return '0;
      q = ((pos - neg) * 64'(res_a)) / den;
      return (q > 64'hFFFF) ? avcm_pkg::OHM_SAT : q[15:0];
    endfunction

    function void note_beat(logic [2:0] kind, logic [14:0] v);
      meter_reading_t r;
      logic [1:0] nr;
      logic [63:0] diff;
      int n;
      r = '0;
      case (kind)
        avcm_pkg::KIND_VOLT: begin
          if (v > max_mv) max_mv = v;
          if (v >= high_thr) nr = avcm_pkg::RANGE_TOP;
          else if (v <= low_thr) nr = avcm_pkg::RANGE_LOW;
          else nr = avcm_pkg::RANGE_MID;
          r.range_changed = (nr != range);
          range = nr;
        end
        avcm_pkg::KIND_OHMS: begin
          r.resistance_ohms = bridge_ohms(v);
          diff = (r.resistance_ohms > last_ohms) ? 64'(r.resistance_ohms - last_ohms)
                                                 : 64'(last_ohms - r.resistance_ohms);
          if (100 * diff > 64'(tol_pct) * 64'(r.resistance_ohms)) begin
            // rejected reading replaces the stored one
            last_ohms = r.resistance_ohms;
            r.ohm_status = avcm_pkg::OHM_NONE;
          end else if (r.resistance_ohms > open_thr) begin
            r.ohm_status = avcm_pkg::OHM_OPEN;
          end else if (r.resistance_ohms < limit_ohms) begin
            r.ohm_status = avcm_pkg::OHM_SHORT;
            tone = 1'b1;
          end else begin
            r.ohm_status = avcm_pkg::OHM_CLOSED;
            tone = 1'b0;
          end
        end
        avcm_pkg::KIND_LIMIT_DOWN: begin
          n = int'(limit_ohms) - StepOhms;
          if (n <= FloorOhms) n = FloorOhms;
          limit_ohms = n[15:0];
        end
        avcm_pkg::KIND_LIMIT_UP: begin
          n = int'(limit_ohms) + StepOhms;
          if (n > CeilOhms) n = CeilOhms;
          limit_ohms = n[15:0];
        end
        avcm_pkg::KIND_MAX_RESET: max_mv = '0;
        default: ;
      endcase
      r.range_sel = range;
      r.alert_on = (range == avcm_pkg::RANGE_TOP);
      r.max_hold_mv = max_mv;
      r.tone_on = tone;
      r.limit_value_ohms = limit_ohms;
      owed.push_back(r);
    endfunction

    function void check_beat(meter_reading_t got);
      meter_reading_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [19:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i = '0;
  logic [14:0] sample_mv_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  range_sel_o;
  logic        range_changed_o;
  logic        alert_on_o;
  logic [14:0] max_hold_mv_o;
  logic [15:0] resistance_ohms_o;
  logic [1:0]  ohm_status_o;
  logic        tone_on_o;
  logic [15:0] limit_value_ohms_o;
  meter_reading_t got;

  meter_scoreboard sb;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;      // last part of the run: no idling on either side
  bit  hold_off = 1'b0;   // long receiver hold-off request
  bit  stim_done = 1'b0;

  assign got = {range_sel_o, range_changed_o, alert_on_o, max_hold_mv_o,
                resistance_ohms_o, ohm_status_o, tone_on_o, limit_value_ohms_o};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  autorange_volt_and_continuity_meter_core dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .kind_i, .sample_mv_i,
    .out_valid_o, .out_stall_i,
    .range_sel_o, .range_changed_o,
    .alert_on_o, .max_hold_mv_o,
    .resistance_ohms_o, .ohm_status_o,
    .tone_on_o, .limit_value_ohms_o
  );

  // result side: check on the rising edge, stall decided on the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_beat(got);
  end

  initial begin
    int burst;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        // long hold-off so the block backs up into its input
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles where no beat of either channel moves
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_beat(logic [2:0] kind, logic [14:0] v);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    sample_mv_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_beat(kind, v);
    @(negedge clk_i);
  endtask

  // registers only change once the block has drained
  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // sample voltage picked near the interesting parts of the current setting
  function automatic logic [14:0] pick_mv(logic [2:0] kind);
    case ($urandom_range(0, 5))
      0: return 15'($urandom_range(0, 32767));
      1: return (kind == avcm_pkg::KIND_OHMS) ? 15'($urandom_range(0, 3)) : sb.low_thr;
      2: return (kind == avcm_pkg::KIND_OHMS) ? 15'(sb.ref_mv) : sb.high_thr;
      default: return (kind == avcm_pkg::KIND_OHMS) ? 15'($urandom_range(0, sb.ref_mv))
                                                    : 15'($urandom_range(0, 25000));
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [2:0] k;
    logic [14:0] v;
    int rep;
    for (int i = 0; i < count; i++) begin
      k = 3'($urandom_range(0, 7));
      if (k > avcm_pkg::KIND_MAX_RESET && $urandom_range(0, 3) != 0) k = avcm_pkg::KIND_OHMS;
      v = pick_mv(k);
      // repeat ohms samples so readings pass the tolerance test
      rep = (k == avcm_pkg::KIND_OHMS) ? $urandom_range(1, 3) : 1;
      for (int j = 0; j < rep; j++)
        send_beat(k, (j > 0 && $urandom_range(0, 1)) ? v + 15'($urandom_range(0, 2)) : v);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, every kind, special cases at reset settings
    send_beat(avcm_pkg::KIND_VOLT, 15'd0);
    send_beat(avcm_pkg::KIND_VOLT, 15'd10000);
    send_beat(avcm_pkg::KIND_VOLT, 15'd10001);
    send_beat(avcm_pkg::KIND_VOLT, 15'd20000);
    send_beat(avcm_pkg::KIND_VOLT, 15'h7FFF);
    send_beat(avcm_pkg::KIND_MAX_RESET, 15'h7FFF);
    send_beat(avcm_pkg::KIND_OHMS, 15'd0);
    send_beat(avcm_pkg::KIND_OHMS, 15'd0);
    send_beat(avcm_pkg::KIND_OHMS, 15'h7FFF);
    send_beat(avcm_pkg::KIND_OHMS, 15'h7FFF);
    send_beat(avcm_pkg::KIND_OHMS, 15'd1600);
    send_beat(avcm_pkg::KIND_OHMS, 15'd1600);
    send_beat(avcm_pkg::KIND_OHMS, 15'd1000);
    send_beat(avcm_pkg::KIND_OHMS, 15'd1000);
    send_beat(avcm_pkg::KIND_LIMIT_DOWN, 15'd0);
    for (int i = 0; i < 21; i++) send_beat(avcm_pkg::KIND_LIMIT_UP, 15'h5555);
    send_beat(avcm_pkg::KIND_OHMS, 15'd1000);
    send_beat(3'd5, 15'h2AAA);
    send_beat(3'd7, 15'd0);

    random_phase(200);
    // long receiver hold-off while beats keep coming
    hold_off = 1'b1;
    random_phase(80);

    // inverted thresholds, wide tolerance, extreme bridge values
    write_reg(avcm_pkg::REG_LOW_THR, 20'h7FFF);
    write_reg(avcm_pkg::REG_HIGH_THR, 20'd0);
    write_reg(avcm_pkg::REG_TOL_PCT, 20'd100);
    write_reg(avcm_pkg::REG_RES_A, 20'hFFFFF);
    write_reg(avcm_pkg::REG_RES_C, 20'd0);
    write_reg(avcm_pkg::REG_RES_D, 20'd1);
    write_reg(avcm_pkg::REG_REF_MV, 20'hFFF);
    write_reg(avcm_pkg::REG_OPEN_THR, 20'hFFFF);
    random_phase(200);

    write_reg(avcm_pkg::REG_LOW_THR, 20'd0);
    write_reg(avcm_pkg::REG_HIGH_THR, 20'h7FFF);
    write_reg(avcm_pkg::REG_TOL_PCT, 20'd0);
    write_reg(avcm_pkg::REG_RES_A, 20'd1);
    write_reg(avcm_pkg::REG_RES_C, 20'hFFFFF);
    write_reg(avcm_pkg::REG_RES_D, 20'hFFFFF);
    write_reg(avcm_pkg::REG_REF_MV, 20'd0);
    write_reg(avcm_pkg::REG_OPEN_THR, 20'd0);
    random_phase(170);

    // random settings per phase
    for (int p = 0; p < 3; p++) begin
      write_reg(avcm_pkg::REG_LOW_THR, 20'($urandom_range(0, 32767)));
      write_reg(avcm_pkg::REG_HIGH_THR, 20'($urandom_range(0, 32767)));
      write_reg(avcm_pkg::REG_TOL_PCT, 20'($urandom_range(0, 100)));
      write_reg(avcm_pkg::REG_RES_A, 20'($urandom_range(1, 20000)));
      write_reg(avcm_pkg::REG_RES_C, 20'($urandom_range(0, 20000)));
      write_reg(avcm_pkg::REG_RES_D, 20'($urandom_range(1, 20000)));
      write_reg(avcm_pkg::REG_REF_MV, 20'($urandom_range(0, 4095)));
      write_reg(avcm_pkg::REG_OPEN_THR, 20'($urandom_range(0, 65535)));
      random_phase(150);
    end
    quiet = 1'b1;
    random_phase(120);
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // end of run: drain, settle, report
  initial begin
    wait (stim_done);
    while (sb.owed.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
